// ===== design/rce_pkg.sv =====
// rce_pkg: shared types, constants and crc fold functions for record_crc32_engine
// no dependencies
package rce_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_RECORD = 2'd0;
  localparam mode_t MODE_PLAIN  = 2'd1;
  localparam mode_t MODE_BYTE   = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // item held in the header stage, ready for the state stage
  typedef struct packed {
    mode_t       mode;
    logic [31:0] msg_length;
    logic [7:0]  data_byte;
    logic [31:0] seq_crc;
  } stage_t;

  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                 input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // crc register after the eight little-endian bytes of the sequence number
  function automatic logic [31:0] crc_fold_seq(input logic [63:0] seq);
    logic [31:0] c;
    c = CRC_ONES;
    for (int i = 0; i < 8; i++) begin
      c = crc_fold_byte(c, seq[8*i +: 8]);
    end
    return c;
  endfunction

  // four little-endian bytes of the length
  function automatic logic [31:0] crc_fold_len(input logic [31:0] crc_in,
                                                input logic [31:0] len);
    logic [31:0] c;
    c = crc_in;
    for (int i = 0; i < 4; i++) begin
      c = crc_fold_byte(c, len[8*i +: 8]);
    end
    return c;
  endfunction

endpackage

// ===== design/rce_if.sv =====
// rce_if: handshake interfaces for the message input and the crc result channels
// depends on nothing
interface rce_msg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] seq_number;
  logic [31:0] msg_length;
  logic [7:0]  data_byte;

  modport source (output valid, output mode, output seq_number, output msg_length,
                  output data_byte, input ready);
  modport sink (input valid, input mode, input seq_number, input msg_length,
                input data_byte, output ready);
endinterface

interface rce_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        was_record;

  modport source (output valid, output crc_value, output was_record, input ready);
  modport sink (input valid, input crc_value, input was_record, output ready);
endinterface

// ===== design/rce_front.sv =====
// rce_front: input register and header stage that folds the sequence number
// depends on rce_pkg and rce_msg_if
module rce_front (
  input  logic          clk,
  input  logic          rst,
  rce_msg_if.sink       msg,
  output logic          stage_valid,
  output rce_pkg::stage_t stage_item,
  input  logic          take
);
  import rce_pkg::*;

  logic        in_valid;
  mode_t       in_mode;
  logic [63:0] in_seq;
  logic [31:0] in_length;
  logic [7:0]  in_byte;
  logic        stage_free;
  logic        in_free;

  assign stage_free = !stage_valid || take;
  assign in_free    = !in_valid || stage_free;
  assign msg.ready  = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      stage_valid <= 1'b0;
    end else begin
      if (in_free) in_valid <= msg.valid;
      if (stage_free) stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && in_free) begin
      in_mode   <= msg.mode;
      in_seq    <= msg.seq_number;
      in_length <= msg.msg_length;
      in_byte   <= msg.data_byte;
    end
    if (in_valid && stage_free) begin
      stage_item.mode       <= in_mode;
      stage_item.msg_length <= in_length;
      stage_item.data_byte  <= in_byte;
      stage_item.seq_crc    <= crc_fold_seq(in_seq);
    end
  end

endmodule

// ===== design/record_crc32_engine.sv =====
// record_crc32_engine: reflected crc-32 over plain messages and records with header
// depends on rce_pkg, rce_if (rce_msg_if, rce_result_if) and rce_front
//
// usage
//   msg carries one item per transaction: a begin item (mode 0 record, mode 1
//   plain) with seq_number and msg_length, or a payload byte (mode 2).
//   result carries crc_value and was_record, one transaction per finished
//   message: on the last payload byte, or on a begin item with zero length.
//   stray bytes, mode 3 and abandoned messages give no transaction.
// timing
//   three stages: input register, header fold of the sequence number, then the
//   state stage (length fold or byte fold) that loads the output register.
//   a result is offered from the output register once its item has passed the input register and the header stage.
//   one item per cycle is sustained while result is not stalled; the byte fold
//   against the running crc in the state stage is the only loop.
// reset and stalls
//   rst (synchronous) empties the pipeline and output, sets the crc register to
//   all ones and closes any open message.
//   while result is stalled, items that give no result still pass; an item that
//   would give one waits in the state stage, and the stages behind it fill up
//   before msg.ready drops.
module record_crc32_engine (
  input  logic          clk,
  input  logic          rst,
  rce_msg_if.sink       msg,
  rce_result_if.source  result
);
  import rce_pkg::*;

  logic        stage_valid;
  stage_t      stage_item;
  logic        take;

  logic [31:0] running_crc;
  logic [31:0] running_crc_next;
  logic [31:0] bytes_left;
  logic [31:0] bytes_left_next;
  logic        record_flag;
  logic        record_flag_next;

  logic        out_valid;
  logic [31:0] crc_value;
  logic        was_record;
  logic        emit;
  logic        out_free;

  rce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .msg         (msg),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .take        (take)
  );

  always_comb begin
    running_crc_next = running_crc;
    bytes_left_next  = bytes_left;
    record_flag_next = record_flag;
    emit             = 1'b0;
    case (stage_item.mode)
      MODE_RECORD: begin
        running_crc_next = crc_fold_len(stage_item.seq_crc, stage_item.msg_length);
        bytes_left_next  = stage_item.msg_length;
        record_flag_next = 1'b1;
        emit             = (stage_item.msg_length == 32'd0);
      end
      MODE_PLAIN: begin
        running_crc_next = CRC_ONES;
        bytes_left_next  = stage_item.msg_length;
        record_flag_next = 1'b0;
        emit             = (stage_item.msg_length == 32'd0);
      end
      MODE_BYTE: begin
        if (bytes_left != 32'd0) begin
          running_crc_next = crc_fold_byte(running_crc, stage_item.data_byte);
          bytes_left_next  = bytes_left - 32'd1;
          emit             = (bytes_left == 32'd1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || result.ready;
  assign take     = stage_valid && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_ONES;
      bytes_left  <= 32'd0;
      record_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        running_crc <= running_crc_next;
        bytes_left  <= bytes_left_next;
        record_flag <= record_flag_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      crc_value  <= running_crc_next ^ CRC_ONES;
      was_record <= record_flag_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.crc_value  = crc_value;
  assign result.was_record = was_record;

  // no message stays open once its crc is out
  assert property (@(posedge clk) disable iff (rst)
    (take && emit) |=> (bytes_left == 32'd0))
    else $error("message still open after crc transaction");

  // a stray byte must not disturb the crc register
  assert property (@(posedge clk) disable iff (rst)
    (take && stage_item.mode == MODE_BYTE && bytes_left == 32'd0)
      |=> $stable(running_crc))
    else $error("stray byte changed the crc register");

  // empty plain message gives the crc of the empty string
  assert property (@(posedge clk) disable iff (rst)
    (take && stage_item.mode == MODE_PLAIN && stage_item.msg_length == 32'd0)
      |=> (out_valid && crc_value == 32'd0 && !was_record))
    else $error("wrong result for empty plain message");

endmodule

// ===== tb/record_crc32_engine_tb.sv =====
// record_crc32_engine_tb: self-checking bench for the reflected crc-32 engine
// drives rce_msg_if, checks rce_result_if against a crc predictor; needs rce_pkg,
// rce_if and the record_crc32_engine rtl
module record_crc32_engine_tb;
  import rce_pkg::*;

  localparam mode_t MODE_UNUSED    = 2'd3;
  localparam int    WATCHDOG_LIMIT = 1000;
  localparam int    RANDOM_ITEMS   = 1400;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        was_record;
  } crc_result_t;

  logic clk = 1'b0;
  logic rst;

  rce_msg_if    msg_ch ();
  rce_result_if res_ch ();

  record_crc32_engine dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .result (res_ch)
  );

  crc_result_t expected_crcs[$];
  crc_result_t oldest_crc;
  logic [31:0] msg_crc_reg;
  logic [31:0] msg_bytes_left;
  logic        msg_is_record;
  int          fail_count  = 0;
  int          stall_left  = 0;
  int          idle_cycles = 0;
  bit          src_idle;
  bit          sink_idle;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] crc_byte_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    int          k;
    r = c ^ {24'd0, b};
    for (k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void predict_crc_result(mode_t m, logic [63:0] seq, logic [31:0] len,
                                             logic [7:0] b);
    logic [31:0] c;
    crc_result_t r;
    int          i;
    case (m)
      MODE_RECORD, MODE_PLAIN: begin
        c = CRC_ONES;
        if (m == MODE_RECORD) begin
          for (i = 0; i < 8; i++) c = crc_byte_step(c, seq[8*i +: 8]);
          for (i = 0; i < 4; i++) c = crc_byte_step(c, len[8*i +: 8]);
        end
        msg_crc_reg    = c;
        msg_bytes_left = len;
        msg_is_record  = (m == MODE_RECORD);
        if (len == 32'd0) begin
          r.crc_value  = c ^ CRC_ONES;
          r.was_record = msg_is_record;
          expected_crcs.push_back(r);
        end
      end
      MODE_BYTE: begin
        if (msg_bytes_left != 32'd0) begin
          msg_crc_reg    = crc_byte_step(msg_crc_reg, b);
          msg_bytes_left = msg_bytes_left - 32'd1;
          if (msg_bytes_left == 32'd0) begin
            r.crc_value  = msg_crc_reg ^ CRC_ONES;
            r.was_record = msg_is_record;
            expected_crcs.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(mode_t m, logic [63:0] seq, logic [31:0] len, logic [7:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      msg_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_ch.mode       = m;
    msg_ch.seq_number = seq;
    msg_ch.msg_length = len;
    msg_ch.data_byte  = b;
    msg_ch.valid      = 1'b1;
    do @(posedge clk); while (msg_ch.ready !== 1'b1);
    predict_crc_result(m, seq, len, b);
  endtask

  task automatic send_message(mode_t m, logic [31:0] len, int nbytes);
    int i;
    send_item(m, {$urandom, $urandom}, len, 8'($urandom_range(0, 255)));
    for (i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(MODE_UNUSED, {$urandom, $urandom}, $urandom, 8'($urandom_range(0, 255)));
      send_item(MODE_BYTE, {$urandom, $urandom}, $urandom, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_results_drained;
    @(negedge clk);
    msg_ch.valid = 1'b0;
    while (expected_crcs.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      stall_left = sink_idle ? $urandom_range(0, 3) : 0;
      if (expected_crcs.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual crc_value %h was_record %b",
                 $time, res_ch.crc_value, res_ch.was_record);
        fail_count++;
      end else begin
        oldest_crc = expected_crcs.pop_front();
        if (res_ch.crc_value !== oldest_crc.crc_value) begin
          $display("%0t: crc_value mismatch, expected %h, actual %h",
                   $time, oldest_crc.crc_value, res_ch.crc_value);
          fail_count++;
        end
        if (res_ch.was_record !== oldest_crc.was_record) begin
          $display("%0t: was_record mismatch, expected %b, actual %b",
                   $time, oldest_crc.was_record, res_ch.was_record);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready = 1'b0;
      stall_left   = stall_left - 1;
    end else begin
      res_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_empty_messages;
    send_item(MODE_PLAIN, 64'd0, 32'd0, 8'd0);
    send_item(MODE_RECORD, 64'd0, 32'd0, 8'd0);
    send_item(MODE_RECORD, '1, 32'd0, 8'hFF);
  endtask

  task automatic test_field_extremes;
    send_item(MODE_PLAIN, 64'd0, 32'd1, 8'd0);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h00);
    send_item(MODE_PLAIN, '1, 32'd1, 8'd0);
    send_item(MODE_BYTE, '1, '1, 8'hFF);
    send_item(MODE_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 8'd0);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'hFF);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h00);
  endtask

  task automatic test_stray_and_unused;
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h5A);
    send_item(MODE_UNUSED, '1, '1, 8'hFF);
    send_item(MODE_PLAIN, 64'd0, 32'd2, 8'd0);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h12);
    send_item(MODE_UNUSED, 64'd0, 32'd0, 8'h00);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h34);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'hC3);
  endtask

  task automatic test_begin_while_open;
    send_item(MODE_RECORD, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF, 8'd0);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h11);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h22);
    send_item(MODE_PLAIN, 64'd0, 32'd3, 8'd0);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h33);
    send_item(MODE_RECORD, 64'h42, 32'd1, 8'd0);
    send_item(MODE_BYTE, 64'd0, 32'd0, 8'h44);
  endtask

  task automatic test_random_traffic;
    int          sent;
    int          phase;
    int          r;
    int          nbytes;
    logic [31:0] len;
    mode_t       m;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < 3 && sent >= (phase + 1) * (RANDOM_ITEMS / 4)) begin
        phase++;
        wait_results_drained();
        src_idle  = (phase == 2);
        sink_idle = (phase == 3);
      end
      r = $urandom_range(0, 99);
      m = $urandom_range(0, 1) ? MODE_RECORD : MODE_PLAIN;
      if (r < 8) begin
        send_item($urandom_range(0, 1) ? MODE_BYTE : MODE_UNUSED, {$urandom, $urandom},
                  $urandom, 8'($urandom_range(0, 255)));
      end else if (r < 15) begin
        // abandoned message, sent with fewer bytes than its length
        len    = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h40) : $urandom_range(2, 20);
        nbytes = $urandom_range(1, (len > 20) ? 5 : int'(len) - 1);
        send_message(m, len, nbytes);
        sent += 1 + nbytes;
      end else begin
        r   = $urandom_range(0, 9);
        len = (r == 0) ? 32'd0 : (r == 9) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_message(m, len, int'(len));
        sent += 1 + int'(len);
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    msg_ch.valid      = 1'b0;
    msg_ch.mode       = MODE_PLAIN;
    msg_ch.seq_number = 64'd0;
    msg_ch.msg_length = 32'd0;
    msg_ch.data_byte  = 8'd0;
    res_ch.ready      = 1'b0;
    msg_crc_reg       = CRC_ONES;
    msg_bytes_left    = 32'd0;
    msg_is_record     = 1'b0;
    src_idle          = 1'b1;
    sink_idle         = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_messages();
    test_field_extremes();
    test_stray_and_unused();
    test_begin_while_open();
    wait_results_drained();
    test_random_traffic();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (expected_crcs.size() != 0) begin
      $display("%0t: %0d results outstanding, expected 0, actual %0d",
               $time, expected_crcs.size(), expected_crcs.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
